[src/owbm_pkg.sv]
`timescale 1ns / 1ps
// Shared types, register indexes and reset values for the one-wire bus master.
// No dependencies; used by owbm_core and one_wire_bus_master.
package owbm_pkg;

    localparam int REG_W    = 10;
    localparam int NUM_REGS = 8;
    localparam int BYTE_W   = 8;
    localparam int BIT_IDX_W = 3;

    // Timing register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_RESET_LOW     = 3'd0,
        REG_PRES_SAMPLE   = 3'd1,
        REG_RESET_TAIL    = 3'd2,
        REG_WRITE_SHORT   = 3'd3,
        REG_WRITE_LONG    = 3'd4,
        REG_READ_LOW      = 3'd5,
        REG_READ_SAMPLE   = 3'd6,
        REG_READ_TAIL     = 3'd7
    } reg_idx_t;

    // Command carried with each tick
    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_RESET = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_READ  = 2'd3
    } kind_t;

    // Reset values of the timing registers (microsecond ticks)
    localparam logic [REG_W-1:0] DEF_RESET_LOW   = 10'd485;
    localparam logic [REG_W-1:0] DEF_PRES_SAMPLE = 10'd65;
    localparam logic [REG_W-1:0] DEF_RESET_TAIL  = 10'd500;
    localparam logic [REG_W-1:0] DEF_WRITE_SHORT = 10'd3;
    localparam logic [REG_W-1:0] DEF_WRITE_LONG  = 10'd65;
    localparam logic [REG_W-1:0] DEF_READ_LOW    = 10'd2;
    localparam logic [REG_W-1:0] DEF_READ_SAMPLE = 10'd13;
    localparam logic [REG_W-1:0] DEF_READ_TAIL   = 10'd45;

    // Released gap closing every write slot
    localparam logic [REG_W-1:0] WRITE_GAP_US = 10'd5;

    // All timing registers, indexed by reg_idx_t
    typedef logic [NUM_REGS-1:0][REG_W-1:0] timing_t;

    // One result beat
    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic              present;
        logic              done_res;
        logic              busy_res;
        logic              drive_low;
    } result_t;

    // A programmed length of zero counts as one tick
    function automatic logic [REG_W-1:0] reg_len(input logic [REG_W-1:0] v);
        reg_len = (v == '0) ? REG_W'(1) : v;
    endfunction

endpackage

[src/owbm_core.sv]
`timescale 1ns / 1ps
// Bus sequencer: operation, phase, tick and bit counters, shift byte and flags.
// Depends on owbm_pkg. Advances one tick per accepted beat.
module owbm_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  owbm_pkg::kind_t     kind,
    input  logic [7:0]          write_data,
    input  logic                line_in,
    input  owbm_pkg::timing_t   timing,
    output owbm_pkg::result_t   result
);
    import owbm_pkg::*;

    typedef enum logic [1:0] {
        OP_IDLE  = 2'd0,
        OP_RESET = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    op_t                  op_reg, op_next, op_cur;
    logic [1:0]           phase_reg, phase_next, phase_cur;
    logic [REG_W-1:0]     tick_reg, tick_next, tick_cur;
    logic [BIT_IDX_W-1:0] bit_reg, bit_next, bit_cur;
    logic [BYTE_W-1:0]    shift_reg, shift_next, shift_cur;
    logic                 pres_reg, pres_next;
    logic [BYTE_W-1:0]    rdata_reg, rdata_next;
    logic [REG_W-1:0]     len;
    logic                 last;
    logic                 cur_bit;
    logic                 drive, busy, done;

    // Next state for one tick
    always_comb
    begin
        op_cur    = op_reg;
        phase_cur = phase_reg;
        tick_cur  = tick_reg;
        bit_cur   = bit_reg;
        shift_cur = shift_reg;
        // a command only starts from idle; that tick is its first
        if (op_reg == OP_IDLE && kind != KIND_TICK)
        begin
            op_cur    = op_t'(kind);
            phase_cur = 2'd0;
            tick_cur  = '0;
            bit_cur   = '0;
            shift_cur = (kind == KIND_WRITE) ? write_data : '0;
        end

        cur_bit = shift_cur[bit_cur];

        // length of the current phase
        unique case (op_cur)
            OP_RESET:
            begin
                if (phase_cur == 2'd0)
                    len = reg_len(timing[REG_RESET_LOW]);
                else if (phase_cur == 2'd1)
                    len = reg_len(timing[REG_PRES_SAMPLE]);
                else
                    len = reg_len(timing[REG_RESET_TAIL]);
            end
            OP_WRITE:
            begin
                if (phase_cur == 2'd0)
                    len = reg_len(cur_bit ? timing[REG_WRITE_SHORT] : timing[REG_WRITE_LONG]);
                else if (phase_cur == 2'd1)
                    len = reg_len(cur_bit ? timing[REG_WRITE_LONG] : timing[REG_WRITE_SHORT]);
                else
                    len = WRITE_GAP_US;
            end
            OP_READ:
            begin
                if (phase_cur == 2'd0)
                    len = reg_len(timing[REG_READ_LOW]);
                else if (phase_cur == 2'd1)
                    len = reg_len(timing[REG_READ_SAMPLE]);
                else
                    len = reg_len(timing[REG_READ_TAIL]);
            end
            default: len = REG_W'(1);
        endcase

        last = ({1'b0, tick_cur} + (REG_W+1)'(1)) >= {1'b0, len};

        op_next    = op_cur;
        phase_next = phase_cur;
        tick_next  = tick_cur;
        bit_next   = bit_cur;
        shift_next = shift_cur;
        pres_next  = pres_reg;
        rdata_next = rdata_reg;
        drive      = 1'b0;
        busy       = 1'b0;
        done       = 1'b0;

        if (op_cur != OP_IDLE)
        begin
            busy  = 1'b1;
            drive = (phase_cur == 2'd0);

            // sample at the end of the released phase
            if (last && phase_cur == 2'd1)
            begin
                if (op_cur == OP_RESET)
                    pres_next = ~line_in;
                else if (op_cur == OP_READ && line_in)
                    shift_next[bit_cur] = 1'b1;
            end

            if (!last)
                tick_next = tick_cur + REG_W'(1);
            else
            begin
                tick_next = '0;
                if (phase_cur != 2'd2)
                    phase_next = phase_cur + 2'd1;
                else if (op_cur == OP_RESET || bit_cur == '1)
                begin
                    if (op_cur == OP_READ)
                        rdata_next = shift_next;
                    done       = 1'b1;
                    op_next    = OP_IDLE;
                    phase_next = 2'd0;
                    bit_next   = '0;
                end
                else
                begin
                    phase_next = 2'd0;
                    bit_next   = bit_cur + BIT_IDX_W'(1);
                end
            end
        end
    end

    // State advances on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg    <= OP_IDLE;
            phase_reg <= 2'd0;
            tick_reg  <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            pres_reg  <= 1'b0;
            rdata_reg <= '0;
        end
        else if (accept)
        begin
            op_reg    <= op_next;
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            pres_reg  <= pres_next;
            rdata_reg <= rdata_next;
        end
    end

    assign result.drive_low = drive;
    assign result.busy_res  = busy;
    assign result.done_res  = done;
    assign result.present   = pres_next;
    assign result.read_data = rdata_next;

`ifndef ASSERT_OFF
    // phase only ever counts low, released, tail
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("phase out of range");

    // idle leaves counters cleared
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        op_reg == OP_IDLE |-> (phase_reg == 2'd0 && tick_reg == '0 && bit_reg == '0))
        else $error("counters not cleared while idle");

    // a done beat returns the sequencer to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && done |=> op_reg == OP_IDLE)
        else $error("operation still running after done");

    // presence only moves during a reset operation
    a_pres_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(pres_reg) |-> $past(op_next) == OP_RESET || $past(op_reg) == OP_RESET
                               || $past(op_cur) == OP_RESET)
        else $error("presence changed outside reset");

    // the read byte only changes on the done tick of a read
    a_rdata_done: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(rdata_reg) |-> $past(done) && $past(accept))
        else $error("read byte changed outside done");
`endif

endmodule

[src/one_wire_bus_master.sv]
`timescale 1ns / 1ps
// Top level of the one-wire bus master: stream ports, timing registers, result register.
// Depends on owbm_pkg and owbm_core.

// Each input beat is one microsecond tick of bus time and yields exactly one
// result beat describing that tick (drive level, busy, done, presence, read
// byte). A beat is taken every clock cycle: the sequencer counters update in
// the cycle the beat is accepted and the result sits in a single output
// register, so one beat per cycle is sustained and a stalled output holds
// back the input only while that register is full and not being taken.
// Commands in tuser start an operation only when the master is idle. The
// timing registers are written through the cfg port (always ready) and
// should only be changed while no operation is running.
module one_wire_bus_master (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] write_data, [8] line_in, rest zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [0] drive_low, [1] busy_res, [2] done_res,
                                        // [3] present, [11:4] read_data, rest zero
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [9:0]  cfg_data
);
    import owbm_pkg::*;

    timing_t  timing_reg;
    result_t  core_res;
    logic     accept;
    logic     m_valid_reg;
    result_t  m_data_reg;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Timing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg[REG_RESET_LOW]   <= DEF_RESET_LOW;
            timing_reg[REG_PRES_SAMPLE] <= DEF_PRES_SAMPLE;
            timing_reg[REG_RESET_TAIL]  <= DEF_RESET_TAIL;
            timing_reg[REG_WRITE_SHORT] <= DEF_WRITE_SHORT;
            timing_reg[REG_WRITE_LONG]  <= DEF_WRITE_LONG;
            timing_reg[REG_READ_LOW]    <= DEF_READ_LOW;
            timing_reg[REG_READ_SAMPLE] <= DEF_READ_SAMPLE;
            timing_reg[REG_READ_TAIL]   <= DEF_READ_TAIL;
        end
        else if (cfg_valid && cfg_ready)
        begin
            timing_reg[cfg_index] <= cfg_data;
        end
    end

    owbm_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .kind       (kind_t'(s_axis_tuser)),
        .write_data (s_axis_tdata[7:0]),
        .line_in    (s_axis_tdata[8]),
        .timing     (timing_reg),
        .result     (core_res)
    );

    // Output register: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (accept)
            m_valid_reg <= 1'b1;
        else if (m_axis_tready)
            m_valid_reg <= 1'b0;
    end

    // Output register: payload
    always_ff @(posedge clk)
    begin
        if (accept)
            m_data_reg <= core_res;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'b0, m_data_reg};

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for one_wire_bus_master: drives microsecond ticks and
// timing writes, predicts every result beat and compares it field by field.
// Depends on owbm_pkg and one_wire_bus_master.
module tb_top;
    import owbm_pkg::*;

    // Bus-timing predictor and store of the result beats still due
    class bus_scoreboard;
        timing_t       timing;
        kind_t         op;
        int unsigned   slot_phase;
        int unsigned   ticks;
        int unsigned   bit_no;
        logic [7:0]    shifter;
        logic          seen_device;
        logic [7:0]    last_read;
        result_t       due_beats[$];
        int            errors;

        function new();
            timing[REG_RESET_LOW]   = DEF_RESET_LOW;
            timing[REG_PRES_SAMPLE] = DEF_PRES_SAMPLE;
            timing[REG_RESET_TAIL]  = DEF_RESET_TAIL;
            timing[REG_WRITE_SHORT] = DEF_WRITE_SHORT;
            timing[REG_WRITE_LONG]  = DEF_WRITE_LONG;
            timing[REG_READ_LOW]    = DEF_READ_LOW;
            timing[REG_READ_SAMPLE] = DEF_READ_SAMPLE;
            timing[REG_READ_TAIL]   = DEF_READ_TAIL;
            op          = KIND_TICK;
            slot_phase  = 0;
            ticks       = 0;
            bit_no      = 0;
            shifter     = '0;
            seen_device = 1'b0;
            last_read   = '0;
            errors      = 0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [REG_W-1:0] v);
            timing[idx] = v;
        endfunction

        function bit busy();
            return op != KIND_TICK;
        endfunction

        // programmed length, zero counting as one tick
        function int unsigned span(reg_idx_t idx);
            return (timing[idx] == '0) ? 1 : int'(timing[idx]);
        endfunction

        function int unsigned stage_len();
            logic cur_bit;
            cur_bit = shifter[bit_no];
            case (op)
                KIND_RESET:
                    if (slot_phase == 0)      return span(REG_RESET_LOW);
                    else if (slot_phase == 1) return span(REG_PRES_SAMPLE);
                    else                      return span(REG_RESET_TAIL);
                KIND_WRITE:
                    if (slot_phase == 0)
                        return cur_bit ? span(REG_WRITE_SHORT) : span(REG_WRITE_LONG);
                    else if (slot_phase == 1)
                        return cur_bit ? span(REG_WRITE_LONG) : span(REG_WRITE_SHORT);
                    else
                        return int'(WRITE_GAP_US);
                default:
                    if (slot_phase == 0)      return span(REG_READ_LOW);
                    else if (slot_phase == 1) return span(REG_READ_SAMPLE);
                    else                      return span(REG_READ_TAIL);
            endcase
        endfunction

        // advance the bus sequencer by one accepted tick and queue its beat
        function void note_tick(kind_t k, logic [7:0] wdata, logic line);
            result_t     r;
            int unsigned len;
            bit          last;
            r = '0;
            if (op == KIND_TICK && k != KIND_TICK) begin
                op         = k;
                slot_phase = 0;
                ticks      = 0;
                bit_no     = 0;
                shifter    = (k == KIND_WRITE) ? wdata : 8'h00;
            end
            if (op != KIND_TICK) begin
                len         = stage_len();
                last        = (ticks + 1 >= len);
                r.busy_res  = 1'b1;
                r.drive_low = (slot_phase == 0);
                // sample point at the end of the released stage
                if (last && slot_phase == 1) begin
                    if (op == KIND_RESET)
                        seen_device = !line;
                    else if (op == KIND_READ && line)
                        shifter[bit_no] = 1'b1;
                end
                if (!last) begin
                    ticks++;
                end
                else begin
                    ticks = 0;
                    if (slot_phase < 2) begin
                        slot_phase++;
                    end
                    else if (op == KIND_RESET || bit_no >= 7) begin
                        if (op == KIND_READ)
                            last_read = shifter;
                        r.done_res = 1'b1;
                        op         = KIND_TICK;
                        slot_phase = 0;
                        bit_no     = 0;
                    end
                    else begin
                        slot_phase = 0;
                        bit_no++;
                    end
                end
            end
            r.present   = seen_device;
            r.read_data = last_read;
            due_beats.push_back(r);
        endfunction

        function void compare(string field, int want, int got);
            if (want != got) begin
                errors++;
                $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
            end
        endfunction

        function void check_beat(logic [15:0] beat);
            result_t want;
            result_t got;
            got = result_t'(beat[11:0]);
            if (due_beats.size() == 0) begin
                errors++;
                $display("%0t: result beat %0h arrived with none expected", $time, beat);
                return;
            end
            want = due_beats.pop_front();
            compare("drive_low", want.drive_low, got.drive_low);
            compare("busy_res",  want.busy_res,  got.busy_res);
            compare("done_res",  want.done_res,  got.done_res);
            compare("present",   want.present,   got.present);
            compare("read_data", want.read_data, got.read_data);
        endfunction
    endclass

    localparam int STALL_LIMIT = 2000;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = KIND_TICK;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index     = REG_RESET_LOW;
    logic [9:0]  cfg_data      = '0;

    int            sender_pct = 0;
    int            recv_pct   = 0;
    int            quiet_cycles = 0;
    bus_scoreboard sb = new();

    always #2 clk = ~clk;

    one_wire_bus_master dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // result side: check each accepted beat, stall at random
    always @(posedge clk) begin
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_beat(m_axis_tdata);
            m_axis_tready <= ($urandom_range(99) >= recv_pct);
        end
    end

    // watchdog: cycles with no beat on any channel
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // 0 and 1 hold the line, 2 samples it at random
    function automatic logic pick_line(int policy);
        if (policy == 0) return 1'b0;
        if (policy == 1) return 1'b1;
        return 1'($urandom);
    endfunction

    // one input beat; valid stays up afterwards unless the next call idles
    task automatic send_tick(input kind_t k, input logic [7:0] wdata, input logic line);
        while (sender_pct > 0 && $urandom_range(99) < sender_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= k;
        s_axis_tdata  <= {7'b0, line, wdata};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_tick(k, wdata, line);
    endtask

    // feed plain ticks until the sequencer is idle and every beat is back
    task automatic drain_to_idle();
        while (sb.busy())
            send_tick(KIND_TICK, 8'($urandom), pick_line(2));
        s_axis_tvalid <= 1'b0;
        while (sb.due_beats.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic load_timing(input timing_t vals);
        reg_idx_t idx;
        idx = idx.first();
        do begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= vals[idx];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            sb.write_reg(idx, vals[idx]);
            idx = idx.next();
        end while (idx != idx.first());
        cfg_valid <= 1'b0;
    endtask

    function automatic timing_t random_timing(int lo, int hi);
        timing_t  vals;
        reg_idx_t idx;
        idx = idx.first();
        do begin
            vals[idx] = REG_W'($urandom_range(hi, lo));
            idx = idx.next();
        end while (idx != idx.first());
        return vals;
    endfunction

    // one command run to completion; optionally a command thrown in while busy
    task automatic run_op(input kind_t k, input logic [7:0] wdata, input int policy,
                          input bit poke);
        send_tick(k, wdata, pick_line(policy));
        if (poke && sb.busy())
            send_tick(kind_t'($urandom_range(KIND_READ, KIND_RESET)), ~wdata,
                      pick_line(policy));
        while (sb.busy())
            send_tick(KIND_TICK, 8'($urandom), pick_line(policy));
    endtask

    // random beats: mostly commands issued at idle, some noise
    task automatic random_phase(input int n, input int lo, input int hi,
                                input int s_pct, input int r_pct);
        int    sent;
        int    policy;
        kind_t k;
        sender_pct = s_pct;
        recv_pct   = r_pct;
        load_timing(random_timing(lo, hi));
        sent   = 0;
        policy = 2;
        while (sent < n) begin
            if (!sb.busy() && $urandom_range(99) < 85) begin
                k      = kind_t'($urandom_range(KIND_READ, KIND_RESET));
                policy = $urandom_range(2);
            end
            else if (sb.busy() && $urandom_range(99) < 8)
                k = kind_t'($urandom_range(KIND_READ, KIND_RESET));
            else
                k = KIND_TICK;
            send_tick(k, 8'($urandom), pick_line(policy));
            sent++;
        end
        drain_to_idle();
    endtask

    initial begin
        timing_t vals;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // shortest timing, every command and corner, no idling
        sender_pct = 0;
        recv_pct   = 0;
        vals = {NUM_REGS{REG_W'(1)}};
        load_timing(vals);
        send_tick(KIND_TICK, 8'hFF, 1'b1);
        send_tick(KIND_TICK, 8'h00, 1'b0);
        run_op(KIND_RESET, 8'h00, 0, 1'b0);
        run_op(KIND_RESET, 8'hFF, 1, 1'b1);
        run_op(KIND_WRITE, 8'hA5, 2, 1'b1);
        run_op(KIND_READ, 8'h5A, 1, 1'b0);
        run_op(KIND_READ, 8'hFF, 0, 1'b1);
        run_op(KIND_RESET, 8'h00, 1, 1'b0);
        send_tick(KIND_TICK, 8'h3C, 1'b0);
        drain_to_idle();

        // random stretches under the different idling patterns
        random_phase(120, 0, 0, 76, 0);
        random_phase(120, 1, 6, 0, 76);
        random_phase(120, 0, 8, 20, 20);
        random_phase(120, 1, 4, 0, 0);

        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.due_beats.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[one_wire_bus_master.f]
src/owbm_pkg.sv
src/owbm_core.sv
src/one_wire_bus_master.sv
tb/tb_top.sv
